// ===== rtl/slt_pkg.sv =====
// shared types, character codes and helper functions of the script line tokenizer
package slt_pkg;

	localparam int MAX_ROW_DEF = 1024;

	typedef enum logic [2:0] {
		TK_IGNORE = 3'd0,
		TK_EOL    = 3'd1,
		TK_EOR    = 3'd2,
		TK_NAME   = 3'd3,
		TK_BOOL   = 3'd4,
		TK_NUMBER = 3'd5,
		TK_STRING = 3'd6
	} tok_kind_t;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_NAME    = 3'd1,
		M_NUMBER  = 3'd2,
		M_NUMDOT  = 3'd3,
		M_SLASH   = 3'd4,
		M_COMMENT = 3'd5,
		M_STRING  = 3'd6,
		M_STRESC  = 3'd7
	} scan_mode_t;

	typedef struct packed {
		tok_kind_t   kind;
		logic [9:0]  start;
		logic [10:0] len;
	} token_t;

	// up to three tokens caused by one input item, lowest index first
	typedef struct packed {
		logic [1:0]       count;
		token_t [2:0]     tok;
	} token_group_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_DOT    = 8'h2e;
	localparam logic [7:0] CH_SLASH  = 8'h2f;
	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_USCORE = 8'h5f;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_F      = 8'h66;

	localparam logic [31:0] WORD_TRUE  = "true";
	localparam logic [39:0] WORD_FALSE = "false";

	// bool match progress: prefix of true in 1..4, prefix of false in 5..9
	localparam logic [3:0] BM_NONE       = 4'd0;
	localparam logic [3:0] BM_TRUE_1     = 4'd1;
	localparam logic [3:0] BM_TRUE_DONE  = 4'd4;
	localparam logic [3:0] BM_FALSE_1    = 4'd5;
	localparam logic [3:0] BM_FALSE_DONE = 4'd9;

	function automatic logic is_letter(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	function automatic logic [3:0] bool_next(input logic [3:0] s, input logic [7:0] b);
		logic [3:0] r;
		logic [3:0] i;
		r = BM_NONE;
		i = s - BM_TRUE_DONE;
		if (s >= BM_TRUE_1 && s < BM_TRUE_DONE) begin
			if (b == WORD_TRUE[8*(3-s) +: 8])
				r = s + 4'd1;
		end else if (s >= BM_FALSE_1 && s < BM_FALSE_DONE) begin
			if (b == WORD_FALSE[8*(4-i) +: 8])
				r = s + 4'd1;
		end
		return r;
	endfunction

endpackage

// ===== rtl/slt_scan.sv =====
// scan state registers and the per-byte token logic
module slt_scan #(
	parameter int MAX_ROW = slt_pkg::MAX_ROW_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 accept,
	input  logic                 kind,
	input  logic [7:0]           ch,
	output slt_pkg::token_group_t res
);
	import slt_pkg::*;

	localparam int CW = $clog2(MAX_ROW + 1);
	localparam int SW = $clog2(MAX_ROW);
	localparam int DW = CW + 1;
	localparam int LW = (DW > 11) ? DW : 11;
	localparam logic [CW-1:0] COL_MAX   = CW'(MAX_ROW);
	localparam logic [SW-1:0] START_MAX = SW'(MAX_ROW - 1);

	scan_mode_t    mode_q, mode_d;
	logic [CW-1:0] col_q, col_d;
	logic [SW-1:0] ts_q, ts_d;
	logic [3:0]    bm_q, bm_d;
	logic          re_q, re_d;

	logic [DW-1:0] c, tsx, dot;
	logic [1:0]    fl_n;
	token_t        fl0, fl1, ext;
	logic          do_flush, has_ext, fresh;
	token_t        t [3];
	logic [1:0]    n;

	function automatic logic [SW-1:0] sat(input logic [DW-1:0] v);
		return (v < DW'(MAX_ROW)) ? v[SW-1:0] : START_MAX;
	endfunction

	function automatic logic [DW-1:0] diff(input logic [DW-1:0] a, input logic [DW-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	function automatic token_t mk(input tok_kind_t k, input logic [SW-1:0] st,
			input logic [DW-1:0] ln);
		token_t r;
		logic [LW-1:0] s;
		logic [LW-1:0] l;
		s = LW'(st);
		l = LW'(ln);
		r.kind  = k;
		r.start = s[9:0];
		r.len   = l[10:0];
		return r;
	endfunction

	assign c   = DW'(col_q);
	assign tsx = DW'(ts_q);
	assign dot = diff(c, DW'(1));

	// tokens that close whatever is open at the current column
	always_comb begin
		fl_n = 2'd0;
		fl0  = mk(TK_IGNORE, '0, '0);
		fl1  = mk(TK_IGNORE, '0, '0);
		case (mode_q)
			M_NAME: begin
				fl_n = 2'd1;
				fl0  = mk((bm_q == BM_TRUE_DONE || bm_q == BM_FALSE_DONE) ? TK_BOOL : TK_NAME,
					ts_q, diff(c, tsx));
			end
			M_NUMBER: begin
				fl_n = 2'd1;
				fl0  = mk(TK_NUMBER, ts_q, diff(c, tsx));
			end
			M_NUMDOT: begin
				// number, then the dot that did not join it
				fl_n = 2'd2;
				fl0  = mk(TK_NUMBER, ts_q, diff(dot, tsx));
				fl1  = mk(TK_IGNORE, sat(dot), DW'(1));
			end
			M_SLASH: begin
				fl_n = 2'd1;
				fl0  = mk(TK_IGNORE, ts_q, DW'(1));
			end
			M_COMMENT: begin
				fl_n = 2'd1;
				fl0  = mk(TK_EOL, ts_q, diff(c, tsx));
			end
			M_STRING, M_STRESC: begin
				fl_n = 2'd1;
				fl0  = mk(TK_STRING, ts_q, diff(c, tsx));
			end
			default: begin
				fl_n = 2'd0;
			end
		endcase
	end

	always_comb begin
		mode_d   = mode_q;
		col_d    = col_q;
		ts_d     = ts_q;
		bm_d     = bm_q;
		re_d     = re_q;
		do_flush = 1'b0;
		has_ext  = 1'b0;
		fresh    = 1'b0;
		ext      = mk(TK_IGNORE, '0, '0);
		if (accept) begin
			if (kind) begin
				if (!re_q) begin
					do_flush = 1'b1;
					has_ext  = 1'b1;
					ext      = mk(TK_EOR, sat(c), '0);
				end
				mode_d = M_IDLE;
				col_d  = '0;
				ts_d   = '0;
				bm_d   = BM_NONE;
				re_d   = 1'b0;
			end else if (!re_q) begin
				if (ch == CH_NUL) begin
					do_flush = 1'b1;
					has_ext  = 1'b1;
					ext      = mk(TK_EOR, sat(c), '0);
					mode_d   = M_IDLE;
					re_d     = 1'b1;
				end else begin
					case (mode_q)
						M_NAME: begin
							if (is_letter(ch) || is_digit(ch) || ch == CH_USCORE)
								bm_d = bool_next(bm_q, ch);
							else
								fresh = 1'b1;
						end
						M_NUMBER: begin
							if (ch == CH_DOT)
								mode_d = M_NUMDOT;
							else if (!is_digit(ch))
								fresh = 1'b1;
						end
						M_NUMDOT: begin
							if (is_digit(ch))
								mode_d = M_NUMBER;
							else
								fresh = 1'b1;
						end
						M_SLASH: begin
							if (ch == CH_SLASH)
								mode_d = M_COMMENT;
							else
								fresh = 1'b1;
						end
						M_COMMENT: begin
							if (ch == CH_LF || ch == CH_CR)
								fresh = 1'b1;
						end
						M_STRING: begin
							if (ch == CH_QUOTE) begin
								has_ext = 1'b1;
								ext     = mk(TK_STRING, ts_q, diff(c + DW'(1), tsx));
								mode_d  = M_IDLE;
							end else if (ch == CH_BSLASH) begin
								mode_d = M_STRESC;
							end
						end
						M_STRESC: begin
							mode_d = M_STRING;
						end
						default: begin
							fresh = 1'b1;
						end
					endcase
					if (fresh) begin
						do_flush = (mode_q != M_IDLE);
						mode_d   = M_IDLE;
						ts_d     = sat(c);
						if (ch == CH_LF || ch == CH_CR) begin
							has_ext = 1'b1;
							ext     = mk(TK_EOL, sat(c), DW'(1));
						end else if (is_letter(ch)) begin
							mode_d = M_NAME;
							bm_d   = (ch == CH_T) ? BM_TRUE_1 : (ch == CH_F) ? BM_FALSE_1 : BM_NONE;
						end else if (is_digit(ch)) begin
							mode_d = M_NUMBER;
						end else if (ch == CH_QUOTE) begin
							mode_d = M_STRING;
						end else if (ch == CH_SLASH) begin
							mode_d = M_SLASH;
						end else begin
							has_ext = 1'b1;
							ext     = mk(TK_IGNORE, sat(c), DW'(1));
						end
					end
					if (col_q < COL_MAX)
						col_d = col_q + CW'(1);
				end
			end
		end
	end

	// flushed tokens first, then the one the byte itself causes
	always_comb begin
		n    = do_flush ? fl_n : 2'd0;
		t[0] = fl0;
		t[1] = fl1;
		t[2] = mk(TK_IGNORE, '0, '0);
		if (has_ext) begin
			t[n] = ext;
			n    = n + 2'd1;
		end
		res.count  = n;
		res.tok[0] = t[0];
		res.tok[1] = t[1];
		res.tok[2] = t[2];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_IDLE;
			col_q  <= '0;
			ts_q   <= '0;
			bm_q   <= BM_NONE;
			re_q   <= 1'b0;
		end else begin
			mode_q <= mode_d;
			col_q  <= col_d;
			ts_q   <= ts_d;
			bm_q   <= bm_d;
			re_q   <= re_d;
		end
	end

endmodule

// ===== rtl/slt_outbuf.sv =====
// result register holding up to three tokens, drained one per cycle while the receiver is ready
module slt_outbuf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  slt_pkg::token_group_t res,
	output logic                  ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output slt_pkg::token_t       out_tok,
	output logic                  out_last
);
	import slt_pkg::*;

	logic [1:0] cnt_q;
	token_t     slot_q [3];
	logic       pop;

	assign pop       = (cnt_q != 2'd0) && out_ready;
	assign ready     = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && out_ready);
	assign out_valid = (cnt_q != 2'd0);
	assign out_tok   = slot_q[0];
	assign out_last  = (cnt_q == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (load) begin
			cnt_q <= res.count;
		end else if (pop) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			slot_q[0] <= res.tok[0];
			slot_q[1] <= res.tok[1];
			slot_q[2] <= res.tok[2];
		end else if (pop) begin
			slot_q[0] <= slot_q[1];
			slot_q[1] <= slot_q[2];
		end
	end

endmodule

// ===== rtl/script_line_tokenizer_core.sv =====
// top level of the script line tokenizer
//
// input stream: one item per text byte of a row (tuser = 0, tdata = byte), then one
// end-of-row item (tuser = 1). a nul byte ends the row early; later bytes are dropped
// until the end-of-row item.
// output stream: one item per token, tdata = kind, start column, length; tlast marks
// the final token caused by one input item. an input item causes zero to three tokens.
// tokens that need lookahead (names, numbers, a lone slash) come out with the byte after
// them or with the row end.
// tokens caused by an item are on the output the cycle after it is accepted.
// one input item per cycle while each item causes at most one token and the
// receiver is ready; an item causing more tokens holds the input until its last token
// leaves, as the single output register drains one token per cycle when not stalled.
// a stalled receiver keeps the tokens in the result register; a new item is taken in the
// cycle the last held token leaves. reset empties the result register and returns the
// scanner to the start of a row at column zero.
module script_line_tokenizer_core #(
	parameter int MAX_ROW = slt_pkg::MAX_ROW_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] ch
	input  logic        s_tuser,  // [0] kind
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,  // [2:0] token_kind, [12:3] start_col, [23:13] length
	output logic        m_tlast
);
	import slt_pkg::*;

	logic         accept;
	token_group_t res;
	token_t       tok;

	assign accept = s_tvalid && s_tready;

	slt_scan #(
		.MAX_ROW(MAX_ROW)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.accept(accept),
		.kind  (s_tuser),
		.ch    (s_tdata),
		.res   (res)
	);

	slt_outbuf u_outbuf (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (accept),
		.res      (res),
		.ready    (s_tready),
		.out_valid(m_tvalid),
		.out_ready(m_tready),
		.out_tok  (tok),
		.out_last (m_tlast)
	);

	assign m_tdata = {tok.len, tok.start, tok.kind};

endmodule

// ===== rtl/slt_checker.sv =====
// port-level checks of the script line tokenizer and their bind
module slt_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [23:0] m_tdata,
	input logic        m_tlast
);
	import slt_pkg::*;

	// held tokens block the input side
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while tokens wait");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("stalled token changed");

	// end of row is always the final token of its item and covers no bytes
	a_eor_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2:0] == TK_EOR |-> m_tlast && m_tdata[23:13] == 11'd0)
		else $error("bad end-of-row token");

	a_kind_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[2:0] != 3'd7)
		else $error("undefined token kind");

	// an accepted item never happens without a valid sender
	a_accept_valid: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready && !s_tvalid |-> !(s_tvalid && s_tready))
		else $error("item accepted without valid");

endmodule

bind script_line_tokenizer_core slt_checker u_slt_checker (.*);

// ===== dv/tb_top.sv =====
// self-checking testbench of the script line tokenizer core
`timescale 1ns / 100ps

module tb_top;
	import slt_pkg::*;

	localparam int ROW_LIMIT = MAX_ROW_DEF;
	localparam int RANDOM_ITEMS = 150;

	typedef struct packed {
		tok_kind_t   kind;
		logic [9:0]  start;
		logic [10:0] len;
		logic        last;
	} tok_rec_t;

	typedef struct packed {
		logic        eor;
		logic [7:0]  ch;
		logic        fixed;
		tok_kind_t   kind;
		logic [9:0]  start;
		logic [10:0] len;
	} dir_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;
	logic        m_tlast;

	script_line_tokenizer_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// tokenizer state kept by the testbench
	scan_mode_t  scan_st;
	int unsigned col_cnt;
	int unsigned tok_col;
	logic [7:0]  name_txt [6];
	int          name_len;
	bit          row_done;

	tok_rec_t    step_toks [$];
	tok_rec_t    pending_toks [$];
	int          err_cnt;

	// side channel marking directed items whose token is typed in
	logic        drv_fixed;
	tok_rec_t    drv_fixed_tok;
	int          burst_left;
	int          rand_items;
	logic [7:0]  row_bytes [$];
	int unsigned rx_cyc;

	dir_row_t dir_tab [25] = '{
		'{1'b1, 8'h00, 1'b1, TK_EOR,    10'd0, 11'd0},
		'{1'b0, CH_LF, 1'b1, TK_EOL,    10'd0, 11'd1},
		'{1'b0, CH_CR, 1'b1, TK_EOL,    10'd1, 11'd1},
		'{1'b0, "t",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "r",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "u",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "e",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, " ",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "1",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, ".",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "5",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, ".",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "#",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "/",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "/",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "a",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b1, 8'h00, 1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, CH_QUOTE,  1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, CH_BSLASH, 1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, CH_QUOTE,  1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, 8'hff, 1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, CH_NUL, 1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b0, "q",   1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b1, 8'hff, 1'b0, TK_IGNORE, 10'd0, 11'd0},
		'{1'b1, 8'hff, 1'b1, TK_EOR,    10'd0, 11'd0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic int unsigned clip_col(input int unsigned c);
		return c < ROW_LIMIT ? c : ROW_LIMIT - 1;
	endfunction

	function automatic int unsigned gap0(input int unsigned a, input int unsigned b);
		return a > b ? a - b : 0;
	endfunction

	function automatic bit letter_b(input logic [7:0] b);
		return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
	endfunction

	function automatic bit digit_b(input logic [7:0] b);
		return b >= "0" && b <= "9";
	endfunction

	task automatic add_tok(input tok_kind_t k, input int unsigned st, input int unsigned ln);
		tok_rec_t rec;
		rec.kind  = k;
		rec.start = st[9:0];
		rec.len   = ln[10:0];
		rec.last  = 1'b0;
		step_toks.push_back(rec);
	endtask

	// emit the open token ending at column c; a number with a pending dot also emits the dot
	task automatic close_token(input int unsigned c);
		int unsigned dot;
		bit is_bool;
		is_bool = (name_len == 4 &&
			{name_txt[0], name_txt[1], name_txt[2], name_txt[3]} == "true") ||
			(name_len == 5 &&
			{name_txt[0], name_txt[1], name_txt[2], name_txt[3], name_txt[4]} == "false");
		dot = gap0(c, 1);
		case (scan_st)
			M_NAME:    add_tok(is_bool ? TK_BOOL : TK_NAME, tok_col, gap0(c, tok_col));
			M_NUMBER:  add_tok(TK_NUMBER, tok_col, gap0(c, tok_col));
			M_NUMDOT: begin
				add_tok(TK_NUMBER, tok_col, gap0(dot, tok_col));
				add_tok(TK_IGNORE, clip_col(dot), 1);
			end
			M_SLASH:   add_tok(TK_IGNORE, tok_col, 1);
			M_COMMENT: add_tok(TK_EOL, tok_col, gap0(c, tok_col));
			M_STRING, M_STRESC: add_tok(TK_STRING, tok_col, gap0(c, tok_col));
			default: ;
		endcase
		scan_st = M_IDLE;
	endtask

	task automatic open_token(input logic [7:0] b, input int unsigned c);
		tok_col = clip_col(c);
		if (b == CH_LF || b == CH_CR) begin
			add_tok(TK_EOL, tok_col, 1);
		end else if (letter_b(b)) begin
			scan_st = M_NAME;
			name_txt[0] = b;
			name_len = 1;
		end else if (digit_b(b)) begin
			scan_st = M_NUMBER;
		end else if (b == CH_QUOTE) begin
			scan_st = M_STRING;
		end else if (b == CH_SLASH) begin
			scan_st = M_SLASH;
		end else begin
			add_tok(TK_IGNORE, tok_col, 1);
		end
	endtask

	task automatic row_restart();
		scan_st = M_IDLE;
		col_cnt = 0;
		tok_col = 0;
		name_len = 0;
		row_done = 1'b0;
	endtask

	// works out the tokens caused by one accepted item into step_toks
	task automatic tokenize_item(input logic eor, input logic [7:0] b);
		int unsigned c;
		bit fresh;
		step_toks.delete();
		c = col_cnt;
		fresh = 1'b0;
		if (eor) begin
			if (!row_done) begin
				close_token(c);
				add_tok(TK_EOR, clip_col(c), 0);
			end
			row_restart();
		end else if (!row_done) begin
			if (b == CH_NUL) begin
				close_token(c);
				add_tok(TK_EOR, clip_col(c), 0);
				row_done = 1'b1;
			end else begin
				case (scan_st)
					M_NAME: begin
						if (letter_b(b) || digit_b(b) || b == CH_USCORE) begin
							if (name_len < 6)
								name_txt[name_len] = b;
							if (name_len < 7)
								name_len++;
						end else begin
							close_token(c);
							fresh = 1'b1;
						end
					end
					M_NUMBER: begin
						if (b == CH_DOT)
							scan_st = M_NUMDOT;
						else if (!digit_b(b)) begin
							close_token(c);
							fresh = 1'b1;
						end
					end
					M_NUMDOT: begin
						if (digit_b(b))
							scan_st = M_NUMBER;
						else begin
							close_token(c);
							fresh = 1'b1;
						end
					end
					M_SLASH: begin
						if (b == CH_SLASH)
							scan_st = M_COMMENT;
						else begin
							close_token(c);
							fresh = 1'b1;
						end
					end
					M_COMMENT: begin
						if (b == CH_LF || b == CH_CR) begin
							close_token(c);
							fresh = 1'b1;
						end
					end
					M_STRING: begin
						if (b == CH_QUOTE) begin
							add_tok(TK_STRING, tok_col, gap0(c + 1, tok_col));
							scan_st = M_IDLE;
						end else if (b == CH_BSLASH) begin
							scan_st = M_STRESC;
						end
					end
					M_STRESC: scan_st = M_STRING;
					default: fresh = 1'b1;
				endcase
				if (fresh)
					open_token(b, c);
				if (col_cnt < ROW_LIMIT)
					col_cnt++;
			end
		end
		if (step_toks.size() > 0)
			step_toks[step_toks.size() - 1].last = 1'b1;
	endtask

	// prediction on accepted items, checking on accepted tokens
	always @(posedge clk) begin : token_check
		tok_rec_t want;
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				tokenize_item(s_tuser, s_tdata);
				if (drv_fixed) begin
					want = drv_fixed_tok;
					want.last = 1'b1;
					pending_toks.push_back(want);
				end else begin
					foreach (step_toks[i])
						pending_toks.push_back(step_toks[i]);
				end
			end
			if (m_tvalid && m_tready) begin
				if (pending_toks.size() == 0) begin
					err_cnt++;
					$error("token with none expected: kind %0d start %0d length %0d",
						m_tdata[2:0], m_tdata[12:3], m_tdata[23:13]);
				end else begin
					want = pending_toks.pop_front();
					if (m_tdata[2:0] !== want.kind) begin
						err_cnt++;
						$error("token_kind: expected %0d, got %0d", want.kind, m_tdata[2:0]);
					end
					if (m_tdata[12:3] !== want.start) begin
						err_cnt++;
						$error("start_col: expected %0d, got %0d", want.start, m_tdata[12:3]);
					end
					if (m_tdata[23:13] !== want.len) begin
						err_cnt++;
						$error("length: expected %0d, got %0d", want.len, m_tdata[23:13]);
					end
					if (m_tlast !== want.last) begin
						err_cnt++;
						$error("last: expected %0d, got %0d", want.last, m_tlast);
					end
				end
			end
		end
	end

	// receiver stalls: always ready, coin flip, mostly stalled, periodic pattern of the cycle counter
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_cyc <= 0;
			m_tready <= 1'b0;
		end else begin
			rx_cyc <= rx_cyc + 1;
			case ((rx_cyc / 97) % 4)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= (rx_cyc % 3 == 0);
			endcase
		end
	end

	task automatic send_item(input logic eor, input logic [7:0] ch, input logic fixed,
			input tok_rec_t fx);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tuser <= eor;
		drv_fixed <= fixed;
		drv_fixed_tok <= fx;
		do @(posedge clk); while (!s_tready);
		burst_left--;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			row_bytes.push_back(s[i]);
	endtask

	function automatic logic [7:0] word_byte();
		int r;
		r = $urandom_range(0, 62);
		if (r < 26)
			return 8'("a" + r);
		else if (r < 52)
			return 8'("A" + (r - 26));
		else if (r < 62)
			return 8'("0" + (r - 52));
		return CH_USCORE;
	endfunction

	// append one random lexical piece to the row
	task automatic add_piece();
		string punct;
		logic [7:0] b;
		int n;
		punct = " ,;(){}+-=*";
		case ($urandom_range(0, 11))
			0, 1: begin
				row_bytes.push_back(8'($urandom_range(0, 1) ? "a" + $urandom_range(0, 25)
					: "A" + $urandom_range(0, 25)));
				repeat ($urandom_range(0, 6)) row_bytes.push_back(word_byte());
			end
			2: begin
				case ($urandom_range(0, 4))
					0: push_text("true");
					1: push_text("false");
					2: push_text("tru");
					3: push_text("falsey");
					default: push_text("trUe");
				endcase
			end
			3, 4: begin
				repeat ($urandom_range(1, 4))
					row_bytes.push_back(8'("0" + $urandom_range(0, 9)));
				if ($urandom_range(0, 1)) begin
					row_bytes.push_back(CH_DOT);
					repeat ($urandom_range(0, 3))
						row_bytes.push_back(8'("0" + $urandom_range(0, 9)));
				end
			end
			5: begin
				row_bytes.push_back(CH_QUOTE);
				n = $urandom_range(0, 8);
				repeat (n) begin
					if ($urandom_range(0, 4) == 0) begin
						row_bytes.push_back(CH_BSLASH);
						row_bytes.push_back(8'($urandom_range(1, 255)));
					end else begin
						b = 8'($urandom_range(1, 255));
						if (b == CH_QUOTE || b == CH_BSLASH)
							b = "a";
						row_bytes.push_back(b);
					end
				end
				if ($urandom_range(0, 4) != 0)
					row_bytes.push_back(CH_QUOTE);
			end
			6: begin
				push_text("//");
				repeat ($urandom_range(0, 8)) row_bytes.push_back(8'($urandom_range(1, 255)));
			end
			7: row_bytes.push_back(CH_SLASH);
			8: row_bytes.push_back($urandom_range(0, 1) ? CH_CR : CH_LF);
			9: row_bytes.push_back(punct[$urandom_range(0, punct.len() - 1)]);
			10: row_bytes.push_back(8'($urandom_range(1, 255)));
			default: row_bytes.push_back($urandom_range(0, 3) == 0 ? CH_NUL : 8'h20);
		endcase
	endtask

	task automatic send_row();
		tok_rec_t blank;
		blank = '0;
		foreach (row_bytes[i])
			send_item(1'b0, row_bytes[i], 1'b0, blank);
		send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, blank);
		rand_items += row_bytes.size() + 1;
	endtask

	initial begin
		tok_rec_t fx;
		int target;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= 8'h00;
		s_tuser <= 1'b0;
		drv_fixed <= 1'b0;
		drv_fixed_tok <= '0;
		err_cnt = 0;
		burst_left = 0;
		rand_items = 0;
		row_restart();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			fx.kind = dir_tab[i].kind;
			fx.start = dir_tab[i].start;
			fx.len = dir_tab[i].len;
			fx.last = 1'b1;
			send_item(dir_tab[i].eor, dir_tab[i].ch, dir_tab[i].fixed, fx);
		end

		while (rand_items < RANDOM_ITEMS) begin
			row_bytes.delete();
			target = $urandom_range(1, 40);
			while (row_bytes.size() < target)
				add_piece();
			send_row();
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_toks.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (err_cnt == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
